// ----- hdl/sac_pkg.sv -----
// Shared constants, register codes and control structs for the set-associative cache.
// No dependencies; both cache modules import this package.
package sac_pkg;

  localparam int CACHE_ADDR_BITS   = 16;
  localparam int CACHE_MAX_SETS    = 64;
  localparam int CACHE_MAX_WAYS    = 8;
  localparam int CACHE_MAX_BLOCK   = 64;

  // way index carried between modules; covers up to 16 ways
  localparam int WAY_IDX_W = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_WAYS  = 2'd0;
  localparam logic [1:0] CFG_INDEX = 2'd1;
  localparam logic [1:0] CFG_BLOCK = 2'd2;

  // access kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  // requests to the tag directory
  typedef struct packed {
    logic rd;
    logic commit;
    logic clr;
  } dir_req_t;

  // lookup result of the tag directory
  typedef struct packed {
    logic                 hit;
    logic                 evict;
    logic                 victim_dirty;
    logic [WAY_IDX_W-1:0] way;
  } dir_res_t;

endpackage

// ----- hdl/sac_tagdir.sv -----
// Tag directory: one memory row per set with tag, valid and dirty of every way plus
// the set's fill pointer; lookup, way choice and row update. Depends on sac_pkg.
module sac_tagdir import sac_pkg::*; #(
  parameter int ADDR_BITS = CACHE_ADDR_BITS,
  parameter int MAX_SETS  = CACHE_MAX_SETS,
  parameter int MAX_WAYS  = CACHE_MAX_WAYS,
  localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  localparam int WC_W     = $clog2(MAX_WAYS + 1)
) (
  input  logic                 clk,
  input  dir_req_t             req,
  input  logic [SET_W-1:0]     set_idx,
  input  logic [ADDR_BITS-1:0] tag,
  input  logic                 is_store,
  input  logic [WC_W-1:0]      ways,
  output dir_res_t             res,
  output logic [ADDR_BITS-1:0] victim_tag
);

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int ENT_W = ADDR_BITS + 2;
  localparam int ROW_W = MAX_WAYS * ENT_W + WAY_W;

  logic [ROW_W-1:0]     dir_mem [MAX_SETS];
  logic [ROW_W-1:0]     row_r;
  logic [ROW_W-1:0]     row_nxt;
  logic [MAX_WAYS-1:0]  hit_v;
  logic [MAX_WAYS-1:0]  inv_v;
  logic [MAX_WAYS-1:0]  ent_dirty;
  logic [ADDR_BITS-1:0] ent_tag [MAX_WAYS];
  logic [WAY_W-1:0]     hit_way;
  logic [WAY_W-1:0]     inv_way;
  logic [WAY_W-1:0]     fp;
  logic [WAY_W-1:0]     vway;
  logic [WAY_W-1:0]     way;
  logic                 any_hit;
  logic                 any_inv;
  logic                 evict;

  // clear, update and read the set row
  always_ff @(posedge clk) begin
    if (req.clr) begin
      dir_mem[set_idx] <= '0;
    end else if (req.commit) begin
      dir_mem[set_idx] <= row_nxt;
    end
    if (req.rd) begin
      row_r <= dir_mem[set_idx];
    end
  end

  // compare tags of the ways in use, lowest matching and lowest free way win
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      ent_tag[w]   = row_r[w*ENT_W +: ADDR_BITS];
      ent_dirty[w] = row_r[w*ENT_W + ADDR_BITS];
      hit_v[w]     = (WC_W'(w) < ways) && row_r[w*ENT_W + ADDR_BITS + 1] &&
                     (ent_tag[w] == tag);
      inv_v[w]     = (WC_W'(w) < ways) && !row_r[w*ENT_W + ADDR_BITS + 1];
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_v[w]) hit_way = WAY_W'(w);
      if (inv_v[w]) inv_way = WAY_W'(w);
    end
  end

  // pick the way: hit, else free way, else the oldest fill
  always_comb begin
    fp      = row_r[MAX_WAYS*ENT_W +: WAY_W];
    vway    = (WC_W'(fp) < ways) ? fp : '0;
    any_hit = |hit_v;
    any_inv = |inv_v;
    evict   = !any_hit && !any_inv;
    if (any_hit) begin
      way = hit_way;
    end else if (any_inv) begin
      way = inv_way;
    end else begin
      way = vway;
    end
    res.hit          = any_hit;
    res.evict        = evict;
    res.victim_dirty = evict && ent_dirty[vway];
    res.way          = WAY_IDX_W'(way);
    victim_tag       = ent_tag[vway];
  end

  // build the updated row: new line or dirty mark, advance the fill pointer
  always_comb begin
    row_nxt = row_r;
    if (any_hit) begin
      row_nxt[way*ENT_W + ADDR_BITS] = ent_dirty[way] | is_store;
    end else begin
      row_nxt[way*ENT_W +: ENT_W] = {1'b1, is_store, tag};
    end
    if (evict) begin
      row_nxt[MAX_WAYS*ENT_W +: WAY_W] =
        ((WC_W'(vway) + WC_W'(1)) == ways) ? '0 : WAY_W'(vway + 1'b1);
    end
  end

endmodule

// ----- hdl/set_assoc_write_back_cache_fifo.sv -----
// Top level of the set-associative write-back, write-allocate cache with FIFO replacement.
// Holds the control sequencer, line data memory and backing memory; uses sac_pkg, sac_tagdir.
//
// Usage:
//   Input: a transaction is taken when start is high and busy is low (in_kind, in_address,
//   in_size, in_store_data). Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 ways in use, 1 index bits, 2 block bits); write only while the cache is idle.
//   Result: out_valid pulses for one cycle with hit, replaced, victim dirty,
//   victim block address and read_data; the receiver cannot stall, so nothing is held.
// Sequence (NW = 8-byte words per block, at least 1):
//   hit: lookup, then the access steps; the next transaction can be taken in the cycle in
//   which the result is shown. A clean miss first refills the NW words of the block; a miss
//   that evicts a dirty line first writes the victim back. The rate is set by the 8-byte
//   ports of the line memory and of the backing memory: the victim is written
//   back one word a cycle, then the block is refilled one word a cycle.
// Reset: a clearing pass zeroes the backing memory one 8-byte word a cycle and the tag
//   directory one set a cycle; busy stays high until both are cleared. Configuration
//   writes are taken meanwhile.
module set_assoc_write_back_cache_fifo import sac_pkg::*; #(
  parameter int ADDR_BITS       = CACHE_ADDR_BITS,
  parameter int MAX_SETS        = CACHE_MAX_SETS,
  parameter int MAX_WAYS        = CACHE_MAX_WAYS,
  parameter int MAX_BLOCK_BYTES = CACHE_MAX_BLOCK
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [15:0] in_address,
  input  logic [3:0]  in_size,
  input  logic [63:0] in_store_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output logic        out_valid,
  output logic        out_hit,
  output logic        out_replaced,
  output logic        out_victim_dirty,
  output logic [15:0] out_victim_addr,
  output logic [63:0] out_read_data
);

  localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WC_W      = $clog2(MAX_WAYS + 1);
  localparam int IB_MAX    = $clog2(MAX_SETS + 1) - 1;
  localparam int BB_MAX    = $clog2(MAX_BLOCK_BYTES + 1) - 1;
  localparam int WPL       = (BB_MAX >= 3) ? (1 << BB_MAX) / 8 : 1;
  localparam int LW_W      = (WPL > 1) ? $clog2(WPL) : 1;
  localparam int CNT_W     = $clog2(WPL + 1);
  localparam int LDEPTH    = MAX_SETS * MAX_WAYS * WPL;
  localparam int LA_W      = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int OFF_W     = (BB_MAX > 3) ? BB_MAX : 3;
  localparam int BS_W      = OFF_W + 1;
  localparam int MW_W      = ADDR_BITS - 3;
  localparam int MEM_WORDS = 1 << MW_W;
  localparam int CLR_N     = (MEM_WORDS > MAX_SETS) ? MEM_WORDS : MAX_SETS;
  localparam int CLR_W     = $clog2(CLR_N);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_WB, S_FILL, S_ACC0, S_ACC1, S_ACC2
  } state_t;

  state_t               state_r;
  logic [CLR_W-1:0]     clr_cnt_r;

  // configuration
  logic [3:0]           ways_cfg_r;
  logic [2:0]           ib_cfg_r;
  logic [2:0]           bb_cfg_r;
  logic [WC_W-1:0]      ways_eff;
  logic [2:0]           ib_eff;
  logic [2:0]           bb_eff;

  // transaction decode at accept
  logic [ADDR_BITS-1:0] addr_c;
  logic [ADDR_BITS-1:0] blk_mask_c;
  logic [ADDR_BITS-1:0] base_c;
  logic [3:0]           sh_c;
  logic [SET_W-1:0]     set_c;
  logic [ADDR_BITS-1:0] tag_c;
  logic [OFF_W-1:0]     off_c;
  logic [BS_W-1:0]      room_c;
  logic [3:0]           size_c;
  logic [3:0]           n_c;
  logic [CNT_W-1:0]     nw_c;

  // transaction registers
  logic                 kind_r;
  logic [SET_W-1:0]     set_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic [WC_W-1:0]      ways_r;
  logic [3:0]           sh_r;
  logic [2:0]           bb_r;
  logic [2:0]           lane_r;
  logic [LW_W-1:0]      w0_r;
  logic [3:0]           n_r;
  logic                 need1_r;
  logic [MW_W-1:0]      bword_r;
  logic [2:0]           blane_r;
  logic [CNT_W-1:0]     nw_r;
  logic [63:0]          sdata_r;
  logic                 hit_r;
  logic                 evict_r;
  logic                 vdirty_r;
  logic [ADDR_BITS-1:0] vaddr_r;
  logic [LA_W-1:0]      line_base_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 pend_r;
  logic [LW_W-1:0]      pcnt_r;
  logic [63:0]          lo_r;

  // tag directory
  dir_req_t             dir_req;
  dir_res_t             dir_res;
  logic [SET_W-1:0]     dir_set;
  logic [ADDR_BITS-1:0] victim_tag;
  logic [ADDR_BITS-1:0] vaddr_c;
  logic [LA_W-1:0]      line_base_c;

  // memories and their ports
  logic [63:0]          line_mem [LDEPTH];
  logic [63:0]          back_mem [MEM_WORDS];
  logic                 ln_re;
  logic [LA_W-1:0]      ln_raddr;
  logic [63:0]          ln_q_r;
  logic [7:0]           ln_be;
  logic [LA_W-1:0]      ln_waddr;
  logic [63:0]          ln_wdata;
  logic                 bk_re;
  logic [MW_W-1:0]      bk_raddr;
  logic [63:0]          bk_q_r;
  logic [7:0]           bk_be;
  logic [MW_W-1:0]      bk_waddr;
  logic [63:0]          bk_wdata;

  // byte lanes
  logic [7:0]           blk_lanes;
  logic [7:0]           nmask8;
  logic [15:0]          mask16;
  logic [127:0]         sh_data;
  logic [127:0]         rd_full;
  logic [63:0]          keep;
  logic [63:0]          rdata_c;
  logic [LW_W-1:0]      w1;

  // output registers
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic                 out_replaced_r;
  logic                 out_vdirty_r;
  logic [15:0]          out_vaddr_r;
  logic [63:0]          out_rdata_r;

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_replaced     = out_replaced_r;
  assign out_victim_dirty = out_vdirty_r;
  assign out_victim_addr  = out_vaddr_r;
  assign out_read_data    = out_rdata_r;

  // saturate configuration to the built geometry
  always_comb begin
    if (ways_cfg_r == 4'd0) begin
      ways_eff = WC_W'(1);
    end else if (32'(ways_cfg_r) > MAX_WAYS) begin
      ways_eff = WC_W'(MAX_WAYS);
    end else begin
      ways_eff = WC_W'(ways_cfg_r);
    end
    ib_eff = (32'(ib_cfg_r) > IB_MAX) ? 3'(IB_MAX) : ib_cfg_r;
    bb_eff = (32'(bb_cfg_r) > BB_MAX) ? 3'(BB_MAX) : bb_cfg_r;
  end

  // split the address into set, tag, offset and block base
  always_comb begin
    addr_c     = ADDR_BITS'(in_address);
    blk_mask_c = ~({ADDR_BITS{1'b1}} << bb_eff);
    base_c     = addr_c & ~blk_mask_c;
    sh_c       = {1'b0, ib_eff} + {1'b0, bb_eff};
    set_c      = SET_W'((addr_c >> bb_eff) & ~({ADDR_BITS{1'b1}} << ib_eff));
    tag_c      = addr_c >> sh_c;
    off_c      = OFF_W'(addr_c & blk_mask_c);
    room_c     = (BS_W'(1) << bb_eff) - BS_W'(off_c);
    size_c     = (in_size > 4'd8) ? 4'd8 : in_size;
    n_c        = (room_c < BS_W'(size_c)) ? 4'(room_c) : size_c;
    nw_c       = (bb_eff >= 3'd3) ? CNT_W'(1 << (bb_eff - 3'd3)) : CNT_W'(1);
  end

  sac_tagdir #(
    .ADDR_BITS (ADDR_BITS),
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS)
  ) u_dir (
    .clk        (clk),
    .req        (dir_req),
    .set_idx    (dir_set),
    .tag        (tag_r),
    .is_store   (kind_r),
    .ways       (ways_r),
    .res        (dir_res),
    .victim_tag (victim_tag)
  );

  // directory requests: clear pass, lookup read, row update
  always_comb begin
    dir_req = '0;
    dir_set = set_r;
    unique case (state_r)
      S_CLEAR: begin
        dir_set     = SET_W'(clr_cnt_r);
        dir_req.clr = (32'(clr_cnt_r) < MAX_SETS);
      end
      S_IDLE: begin
        dir_set    = set_c;
        dir_req.rd = start;
      end
      S_LOOK: dir_req.commit = 1'b1;
      default: ;
    endcase
  end

  // victim block address and line location of the chosen way
  always_comb begin
    vaddr_c     = (victim_tag << sh_r) | (ADDR_BITS'(set_r) << bb_r);
    line_base_c = LA_W'((32'(set_r) * MAX_WAYS + 32'(dir_res.way)) * WPL);
  end

  // lane masks and data alignment for the access
  always_comb begin
    unique case (bb_r)
      3'd0:    blk_lanes = 8'h01;
      3'd1:    blk_lanes = 8'h03;
      3'd2:    blk_lanes = 8'h0F;
      default: blk_lanes = 8'hFF;
    endcase
    nmask8  = 8'((9'd1 << n_r) - 9'd1);
    mask16  = 16'(nmask8) << lane_r;
    sh_data = 128'(sdata_r) << {lane_r, 3'b000};
    rd_full = {ln_q_r, lo_r} >> {lane_r, 3'b000};
    for (int j = 0; j < 8; j++) begin
      keep[8*j +: 8] = {8{nmask8[j]}};
    end
    rdata_c = (kind_r == KIND_STORE) ? 64'd0 : (rd_full[63:0] & keep);
    w1      = need1_r ? LW_W'(w0_r + 1'b1) : w0_r;
  end

  // drive memory ports per sequencer step
  always_comb begin
    ln_re    = 1'b0;
    ln_raddr = line_base_r;
    ln_be    = '0;
    ln_waddr = line_base_r;
    ln_wdata = '0;
    bk_re    = 1'b0;
    bk_raddr = bword_r;
    bk_be    = '0;
    bk_waddr = bword_r;
    bk_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        bk_be    = (32'(clr_cnt_r) < MEM_WORDS) ? 8'hFF : 8'h00;
        bk_waddr = MW_W'(clr_cnt_r);
      end
      S_WB: begin
        ln_re    = (cnt_r != nw_r);
        ln_raddr = line_base_r + LA_W'(cnt_r);
        if (pend_r) begin
          bk_be    = blk_lanes << vaddr_r[2:0];
          bk_waddr = vaddr_r[ADDR_BITS-1:3] + MW_W'(pcnt_r);
          bk_wdata = ln_q_r << {vaddr_r[2:0], 3'b000};
        end
      end
      S_FILL: begin
        bk_re    = (cnt_r != nw_r);
        bk_raddr = bword_r + MW_W'(cnt_r);
        if (pend_r) begin
          ln_be    = blk_lanes;
          ln_waddr = line_base_r + LA_W'(pcnt_r);
          ln_wdata = bk_q_r >> {blane_r, 3'b000};
        end
      end
      S_ACC0: begin
        ln_raddr = line_base_r + LA_W'(w0_r);
        ln_waddr = line_base_r + LA_W'(w0_r);
        if (kind_r == KIND_STORE) begin
          ln_be    = mask16[7:0];
          ln_wdata = sh_data[63:0];
        end else begin
          ln_re = 1'b1;
        end
      end
      S_ACC1: begin
        ln_raddr = line_base_r + LA_W'(w1);
        ln_waddr = line_base_r + LA_W'(w1);
        if (kind_r == KIND_STORE) begin
          ln_be    = need1_r ? mask16[15:8] : 8'h00;
          ln_wdata = sh_data[127:64];
        end else begin
          ln_re = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // line data memory: byte-enable write, registered read
  always_ff @(posedge clk) begin
    for (int j = 0; j < 8; j++) begin
      if (ln_be[j]) line_mem[ln_waddr][8*j +: 8] <= ln_wdata[8*j +: 8];
    end
    if (ln_re) ln_q_r <= line_mem[ln_raddr];
  end

  // backing memory: byte-enable write, registered read
  always_ff @(posedge clk) begin
    for (int j = 0; j < 8; j++) begin
      if (bk_be[j]) back_mem[bk_waddr][8*j +: 8] <= bk_wdata[8*j +: 8];
    end
    if (bk_re) bk_q_r <= back_mem[bk_raddr];
  end

  // sequencer, configuration and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ways_cfg_r  <= 4'd1;
      ib_cfg_r    <= 3'd0;
      bb_cfg_r    <= 3'd3;
    end else begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WAYS:  ways_cfg_r <= cfg_data;
          CFG_INDEX: ib_cfg_r <= cfg_data[2:0];
          CFG_BLOCK: bb_cfg_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == CLR_W'(CLR_N - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            kind_r  <= in_kind;
            set_r   <= set_c;
            tag_r   <= tag_c;
            ways_r  <= ways_eff;
            sh_r    <= sh_c;
            bb_r    <= bb_eff;
            lane_r  <= off_c[2:0];
            w0_r    <= LW_W'(off_c >> 3);
            n_r     <= n_c;
            need1_r <= ((5'(off_c[2:0]) + 5'(n_c)) > 5'd8);
            bword_r <= base_c[ADDR_BITS-1:3];
            blane_r <= base_c[2:0];
            nw_r    <= nw_c;
            sdata_r <= in_store_data;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          hit_r       <= dir_res.hit;
          evict_r     <= dir_res.evict;
          vdirty_r    <= dir_res.victim_dirty;
          vaddr_r     <= dir_res.evict ? vaddr_c : '0;
          line_base_r <= line_base_c;
          cnt_r       <= '0;
          if (dir_res.victim_dirty) begin
            state_r <= S_WB;
          end else if (!dir_res.hit) begin
            state_r <= S_FILL;
          end else begin
            state_r <= S_ACC0;
          end
        end
        S_WB, S_FILL: begin
          pend_r <= (cnt_r != nw_r);
          pcnt_r <= cnt_r[LW_W-1:0];
          if (cnt_r != nw_r) begin
            cnt_r <= cnt_r + 1'b1;
          end else begin
            cnt_r   <= '0;
            state_r <= (state_r == S_WB) ? S_FILL : S_ACC0;
          end
        end
        S_ACC0: state_r <= S_ACC1;
        S_ACC1: begin
          lo_r    <= ln_q_r;
          state_r <= S_ACC2;
        end
        S_ACC2: begin
          out_valid_r    <= 1'b1;
          out_hit_r      <= hit_r;
          out_replaced_r <= evict_r;
          out_vdirty_r   <= vdirty_r;
          out_vaddr_r    <= 16'(vaddr_r);
          out_rdata_r    <= rdata_c;
          state_r        <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a result follows only the last access step
  a_out_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_ACC2))
    else $error("result strobe without a finished access");

  // an accepted transaction goes straight to lookup
  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_LOOK))
    else $error("accepted transaction did not enter lookup");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_replaced))
    else $error("hit reported together with eviction");

  // a write-back needs an eviction
  a_dirty_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_victim_dirty) |-> out_replaced)
    else $error("write-back reported without eviction");

  // the line memory is left alone while the clearing pass runs
  a_clear_no_line: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (ln_be == 8'h00))
    else $error("line write during clearing pass");

endmodule

// ----- bench/cache_checker.sv -----
// Checker for the set-associative write-back cache: tracks configuration writes,
// predicts one result per accepted transaction and compares the results. Uses sac_pkg.
module cache_checker import sac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_kind,
  input  logic [15:0] in_address,
  input  logic [3:0]  in_size,
  input  logic [63:0] in_store_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        out_valid,
  input  logic        out_hit,
  input  logic        out_replaced,
  input  logic        out_victim_dirty,
  input  logic [15:0] out_victim_addr,
  input  logic [63:0] out_read_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic        hit;
    logic        replaced;
    logic        victim_dirty;
    logic [15:0] victim_addr;
    logic [63:0] read_data;
  } access_result_t;

  // shadow copy of the cache and of the backing memory
  logic [15:0] tag_copy [CACHE_MAX_SETS*CACHE_MAX_WAYS];
  bit          valid_copy [CACHE_MAX_SETS*CACHE_MAX_WAYS];
  bit          dirty_copy [CACHE_MAX_SETS*CACHE_MAX_WAYS];
  logic [7:0]  line_copy [CACHE_MAX_SETS*CACHE_MAX_WAYS*CACHE_MAX_BLOCK];
  logic [2:0]  fill_ptr [CACHE_MAX_SETS];
  logic [7:0]  mem_copy [1 << CACHE_ADDR_BITS];
  logic [3:0]  ways_reg;
  logic [2:0]  index_reg;
  logic [2:0]  block_reg;

  access_result_t expected_results[$];

  initial begin
    errors = 0;
    pending = 0;
    ways_reg = 4'd1;
    index_reg = 3'd0;
    block_reg = 3'd3;
    foreach (valid_copy[i]) begin
      valid_copy[i] = 1'b0;
      dirty_copy[i] = 1'b0;
      tag_copy[i] = '0;
    end
    foreach (fill_ptr[i]) fill_ptr[i] = '0;
    foreach (mem_copy[i]) mem_copy[i] = '0;
    foreach (line_copy[i]) line_copy[i] = '0;
  end

  // Work out one access against the shadow cache and update it
  function automatic access_result_t cache_access(logic kind, logic [15:0] addr,
                                                  logic [3:0] size_in, logic [63:0] sdata);
    access_result_t r;
    int ways, ib, bb, bsize, set, tag, off, base, way, li, nbytes, pos;
    bit found;
    r = '0;
    ways = (ways_reg == 0) ? 1 :
           ((int'(ways_reg) > CACHE_MAX_WAYS) ? CACHE_MAX_WAYS : int'(ways_reg));
    ib = (index_reg > 6) ? 6 : int'(index_reg);
    bb = (block_reg > 6) ? 6 : int'(block_reg);
    nbytes = (size_in > 8) ? 8 : int'(size_in);
    bsize = 1 << bb;
    set = (int'(addr) >> bb) & ((1 << ib) - 1);
    tag = int'(addr) >> (ib + bb);
    off = int'(addr) & (bsize - 1);
    base = int'(addr) & ~(bsize - 1) & 16'hFFFF;
    way = 0;
    found = 0;
    // look for the tag among valid ways
    for (int w = 0; w < ways; w++) begin
      if (!found && valid_copy[set*CACHE_MAX_WAYS + w] &&
          int'(tag_copy[set*CACHE_MAX_WAYS + w]) == tag) begin
        way = w;
        found = 1;
        r.hit = 1'b1;
      end
    end
    if (!found) begin
      // take the lowest invalid way, else evict the oldest fill
      for (int w = 0; w < ways; w++) begin
        if (!found && !valid_copy[set*CACHE_MAX_WAYS + w]) begin
          way = w;
          found = 1;
        end
      end
      if (!found) begin
        way = (int'(fill_ptr[set]) < ways) ? int'(fill_ptr[set]) : 0;
        fill_ptr[set] = 3'((way + 1) % ways);
        li = set*CACHE_MAX_WAYS + way;
        r.replaced = 1'b1;
        r.victim_addr = 16'((int'(tag_copy[li]) << (ib + bb)) | (set << bb));
        if (dirty_copy[li]) begin
          r.victim_dirty = 1'b1;
          for (int k = 0; k < bsize; k++)
            mem_copy[(int'(r.victim_addr) + k) & 16'hFFFF] =
              line_copy[li*CACHE_MAX_BLOCK + k];
        end
      end
      li = set*CACHE_MAX_WAYS + way;
      for (int k = 0; k < bsize; k++)
        line_copy[li*CACHE_MAX_BLOCK + k] = mem_copy[(base + k) & 16'hFFFF];
      tag_copy[li] = 16'(tag);
      valid_copy[li] = 1'b1;
      dirty_copy[li] = 1'b0;
    end
    // read or merge the bytes that fall inside the block
    li = set*CACHE_MAX_WAYS + way;
    for (int k = 0; k < nbytes; k++) begin
      pos = off + k;
      if (pos < bsize) begin
        if (kind == KIND_STORE) line_copy[li*CACHE_MAX_BLOCK + pos] = sdata[8*k +: 8];
        else r.read_data[8*k +: 8] = line_copy[li*CACHE_MAX_BLOCK + pos];
      end
    end
    if (kind == KIND_STORE) dirty_copy[li] = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  // Compare results first, then record the transaction taken at this edge
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_hit !== want.hit)
            report_mismatch("hit", 64'(out_hit), 64'(want.hit));
          if (out_replaced !== want.replaced)
            report_mismatch("replaced", 64'(out_replaced), 64'(want.replaced));
          if (out_victim_dirty !== want.victim_dirty)
            report_mismatch("victim_dirty", 64'(out_victim_dirty), 64'(want.victim_dirty));
          if (out_victim_addr !== want.victim_addr)
            report_mismatch("victim_addr", 64'(out_victim_addr), 64'(want.victim_addr));
          if (out_read_data !== want.read_data)
            report_mismatch("read_data", out_read_data, want.read_data);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_WAYS: ways_reg = cfg_data;
          CFG_INDEX: index_reg = cfg_data[2:0];
          CFG_BLOCK: block_reg = cfg_data[2:0];
          default: ;
        endcase
      end
      if (start && !busy)
        expected_results.push_back(cache_access(in_kind, in_address, in_size, in_store_data));
      pending = expected_results.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the cache testbench: clock, reset, configuration phases and transaction stimulus.
// Depends on sac_pkg, the cache top level and cache_checker.
module tb_top import sac_pkg::*; ();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_kind = KIND_LOAD;
  logic [15:0] in_address = '0;
  logic [3:0]  in_size = 4'd1;
  logic [63:0] in_store_data = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_WAYS;
  logic [3:0]  cfg_data = '0;
  logic        out_valid;
  logic        out_hit;
  logic        out_replaced;
  logic        out_victim_dirty;
  logic [15:0] out_victim_addr;
  logic [63:0] out_read_data;
  int          errors;
  int          pending;
  int          stall_pct;
  int          quiet_cycles = 0;
  logic [15:0] hot_addr [16];

  localparam int QUIET_LIMIT = 40000;

  always #1 clk = ~clk;

  set_assoc_write_back_cache_fifo dut (.*);
  cache_checker checker_i (.*);

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one transaction and hold it until it is taken
  task automatic send_access(logic kind, logic [15:0] addr, logic [3:0] size,
                             logic [63:0] data);
    start <= 1'b1;
    in_kind <= kind;
    in_address <= addr;
    in_size <= size;
    in_store_data <= data;
    do @(posedge clk); while (busy);
    if ($urandom_range(0, 99) < stall_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Raise the write enable with one register write; the caller drops it afterwards
  task automatic write_reg(logic [1:0] idx, logic [3:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Hold off until every outstanding transaction has produced its result
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_access;
    logic [15:0] addr;
    logic [3:0]  size;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) addr = hot_addr[$urandom_range(0, 15)] + 16'($urandom_range(0, 15));
    else addr = 16'($urandom);
    size = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
    send_access(1'($urandom), addr, size, {$urandom, $urandom});
  endtask

  initial begin
    logic [3:0] ways_set  [5] = '{4'd15, 4'd2, 4'd0, 4'd8, 4'd3};
    logic [3:0] index_set [5] = '{4'd7, 4'd2, 4'd1, 4'd0, 4'd6};
    // block size only shrinks, so every cached byte was filled before it is read
    logic [3:0] block_set [5] = '{4'd7, 4'd4, 4'd3, 4'd1, 4'd0};
    stall_pct = 37;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) drain();
      write_reg(CFG_WAYS, ways_set[ph]);
      write_reg(CFG_INDEX, index_set[ph]);
      write_reg(CFG_BLOCK, block_set[ph]);
      cfg_we <= 1'b0;
      stall_pct = (ph < 2) ? 37 : ((ph < 4) ? 66 : 0);
      foreach (hot_addr[i])
        hot_addr[i] = (16'($urandom_range(0, 31)) << 10) | 16'($urandom_range(0, 255));
      if (ph == 0) begin
        // directed: full-size store and load, empty and oversized sizes, block end
        send_access(KIND_STORE, 16'h0000, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(KIND_LOAD, 16'h0000, 4'd8, '0);
        send_access(KIND_LOAD, 16'h0000, 4'd0, '0);
        send_access(KIND_LOAD, 16'h0004, 4'd15, '0);
        send_access(KIND_STORE, 16'h003C, 4'd8, 64'h0123_4567_89AB_CDEF);
        send_access(KIND_LOAD, 16'h0038, 4'd8, '0);
        send_access(KIND_STORE, 16'hFFC0, 4'd8, '0);
        send_access(KIND_LOAD, 16'hFFFF, 4'd1, '0);
        send_access(KIND_STORE, 16'h1000, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        // fill one set past its ways to force dirty and clean evictions
        for (int t = 1; t <= 9; t++)
          send_access(1'(t & 1), 16'(t << 12) | 16'h0005, 4'd4, {$urandom, $urandom});
        send_access(KIND_LOAD, 16'h1000, 4'd8, '0);
        send_access(KIND_LOAD, 16'h0000, 4'd8, '0);
      end
      for (int n = 0; n < 125; n++) random_access();
    end
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
